FILE: hdl/qme_pkg.sv
// Shared types and constants of the queue machine executor.
package qme_pkg;

  localparam int unsigned NUM_REGS = 26;
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned ADDR_W   = 10;
  localparam int unsigned RIDX_W   = 5;
  localparam int unsigned KIND_W   = 5;

  typedef enum logic [KIND_W-1:0] {
    OP_PUSH      = 5'd0,
    OP_ADD       = 5'd1,
    OP_SUB       = 5'd2,
    OP_MUL       = 5'd3,
    OP_DIV       = 5'd4,
    OP_MOD       = 5'd5,
    OP_POP_REG   = 5'd6,
    OP_PUSH_REG  = 5'd7,
    OP_PRN_NUM_Q = 5'd8,
    OP_PRN_NUM_R = 5'd9,
    OP_PRN_CHR_Q = 5'd10,
    OP_PRN_CHR_R = 5'd11,
    OP_JMP       = 5'd12,
    OP_JMP_ZERO  = 5'd13,
    OP_JMP_EQ    = 5'd14,
    OP_JMP_GT    = 5'd15,
    OP_QUIT      = 5'd16
  } qme_op_t;

  localparam logic [1:0] QERR_NONE = 2'd0;
  localparam logic [1:0] QERR_POP  = 2'd1;
  localparam logic [1:0] QERR_PUSH = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [RIDX_W-1:0] reg_a;
    logic [RIDX_W-1:0] reg_b;
    logic [DATA_W-1:0] immediate;
    logic [ADDR_W-1:0] target;
  } qme_cmd_t;

  typedef struct packed {
    logic              print_valid;
    logic [DATA_W-1:0] print_value;
    logic              print_char;
    logic              branch_taken;
    logic [ADDR_W-1:0] branch_target;
    logic              halt;
    logic [1:0]        queue_error;
  } qme_res_t;

endpackage

FILE: hdl/qme_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
interface qme_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/queue_machine_executor_top.sv
// Queue machine execute unit: value queue and register file in synchronous memories.
//
//   channel | dir | payload    | transfer
//   --------+-----+------------+--------------------------
//   cmd     | in  | qme_cmd_t  | valid && ready at clk edge
//   res     | out | qme_res_t  | valid && ready at clk edge
//
// One instruction at a time: a new command is taken only in the idle state, after the last
// one commits; div and mod with a non-zero divisor run a 16-step restoring divider first.
// Queue and register reads go out on the transfer edge; writes land in the commit cycle.
// Synchronous reset clears pointers, count, register valid bits and the control state.
// The result sits in an output register; commit waits only while that register holds a
// result that is not taken in the same cycle.
module queue_machine_executor_top #(
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  qme_stream_if.sink           cmd,
  qme_stream_if.source         res
);
  import qme_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_COMMIT} state_t;

  state_t            state;
  qme_cmd_t          ins;
  logic [PW-1:0]     head;
  logic [PW-1:0]     tail;
  logic [CW-1:0]     count;
  logic [NUM_REGS-1:0] rf_vld;

  // memories
  logic [DATA_W-1:0] q_mem [QUEUE_DEPTH];
  logic [DATA_W-1:0] rf_mem [NUM_REGS];
  logic [DATA_W-1:0] q_rd0, q_rd1, rf_rd_a, rf_rd_b;
  logic              rf_ok_a, rf_ok_b;

  // pending commit
  logic [1:0]        pop_n;
  logic              pop_err;
  logic              push_en;
  logic [DATA_W-1:0] push_val;
  logic              wr_en;
  logic [RIDX_W-1:0] wr_idx;
  logic [DATA_W-1:0] wr_val;
  qme_res_t          rslt;
  qme_res_t          commit_res;

  // divider
  logic [DATA_W-1:0] dv_quo, dv_rem, dv_div;
  logic [3:0]        dv_cnt;
  logic              dv_mod;

  logic              out_valid;
  qme_res_t          out_q;

  logic              accept;
  logic              out_free;
  logic [PW-1:0]     head_p1, head_p2, tail_p1;
  logic [CW-1:0]     count_after;
  logic              push_ok;
  logic              commit;

  // exec stage results
  logic [DATA_W-1:0] x_val, y_val, ra_val, rb_val;
  logic [1:0]        e_pop_need;
  logic [1:0]        e_pop_n;
  logic              e_pop_err;
  logic              e_push_en;
  logic [DATA_W-1:0] e_push_val;
  logic              e_wr_en;
  logic [DATA_W-1:0] e_wr_val;
  logic              e_div;
  qme_res_t          e_res;

  // divider step
  logic [DATA_W:0]   dv_sh;
  logic              dv_ge;
  logic [DATA_W-1:0] dv_rem_next, dv_quo_next;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign out_free  = !out_valid || res.ready;
  assign res.valid   = out_valid;
  assign res.payload = out_q;
  assign commit    = (state == S_COMMIT) && out_free;

  assign head_p1 = (head == PTR_LAST) ? '0 : head + PW'(1);
  assign head_p2 = (head_p1 == PTR_LAST) ? '0 : head_p1 + PW'(1);
  assign tail_p1 = (tail == PTR_LAST) ? '0 : tail + PW'(1);
  assign count_after = count - CW'(pop_n);
  assign push_ok     = push_en && (count_after != CNT_FULL);

  assign x_val  = (count != '0) ? q_rd0 : '0;
  assign y_val  = (count > CW'(1)) ? q_rd1 : '0;
  assign ra_val = rf_ok_a ? rf_rd_a : '0;
  assign rb_val = rf_ok_b ? rf_rd_b : '0;

  always_comb begin
    e_pop_need = 2'd0;
    e_push_en  = 1'b0;
    e_push_val = '0;
    e_wr_en    = 1'b0;
    e_wr_val   = x_val;
    e_div      = 1'b0;
    e_res      = '0;
    unique case (ins.kind)
      OP_PUSH: begin
        e_push_en  = 1'b1;
        e_push_val = ins.immediate;
      end
      OP_ADD: begin
        e_pop_need = 2'd2;
        e_push_en  = 1'b1;
        e_push_val = x_val + y_val;
      end
      OP_SUB: begin
        e_pop_need = 2'd2;
        e_push_en  = 1'b1;
        e_push_val = x_val - y_val;
      end
      OP_MUL: begin
        e_pop_need = 2'd2;
        e_push_en  = 1'b1;
        e_push_val = DATA_W'(x_val * y_val);
      end
      OP_DIV, OP_MOD: begin
        e_pop_need = 2'd2;
        e_push_en  = 1'b1;
        e_div      = (y_val != '0);
      end
      OP_POP_REG: begin
        e_pop_need = 2'd1;
        e_wr_en    = (ins.reg_a < RIDX_W'(NUM_REGS));
      end
      OP_PUSH_REG: begin
        e_push_en  = 1'b1;
        e_push_val = ra_val;
      end
      OP_PRN_NUM_Q: begin
        e_pop_need        = 2'd1;
        e_res.print_valid = 1'b1;
        e_res.print_value = x_val;
      end
      OP_PRN_NUM_R: begin
        e_res.print_valid = 1'b1;
        e_res.print_value = ra_val;
      end
      OP_PRN_CHR_Q: begin
        e_pop_need        = 2'd1;
        e_res.print_valid = 1'b1;
        e_res.print_char  = 1'b1;
        e_res.print_value = {8'd0, x_val[7:0]};
      end
      OP_PRN_CHR_R: begin
        e_res.print_valid = 1'b1;
        e_res.print_char  = 1'b1;
        e_res.print_value = {8'd0, ra_val[7:0]};
      end
      OP_JMP:      e_res.branch_taken = 1'b1;
      OP_JMP_ZERO: e_res.branch_taken = (ra_val == '0);
      OP_JMP_EQ:   e_res.branch_taken = (ra_val == rb_val);
      OP_JMP_GT:   e_res.branch_taken = (ra_val > rb_val);
      OP_QUIT:     e_res.halt = 1'b1;
      default: ;
    endcase
    if (e_res.branch_taken) begin
      e_res.branch_target = ins.target;
    end
    // clip pops to what the queue holds
    if (count >= CW'(e_pop_need)) begin
      e_pop_n   = e_pop_need;
      e_pop_err = 1'b0;
    end else begin
      e_pop_n   = count[1:0];
      e_pop_err = 1'b1;
    end
  end

  always_comb begin
    dv_sh       = {dv_rem, dv_quo[DATA_W-1]};
    dv_ge       = (dv_sh >= {1'b0, dv_div});
    dv_rem_next = dv_ge ? DATA_W'(dv_sh - {1'b0, dv_div}) : dv_sh[DATA_W-1:0];
    dv_quo_next = {dv_quo[DATA_W-2:0], dv_ge};
  end

  always_comb begin
    commit_res             = rslt;
    commit_res.queue_error = pop_err ? QERR_POP :
                             (push_en && !push_ok) ? QERR_PUSH : QERR_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      rf_vld    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && res.ready && !commit) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            ins   <= cmd.payload;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          pop_n    <= e_pop_n;
          pop_err  <= e_pop_err;
          push_en  <= e_push_en;
          push_val <= e_push_val;
          wr_en    <= e_wr_en;
          wr_idx   <= ins.reg_a;
          wr_val   <= e_wr_val;
          rslt     <= e_res;
          dv_quo   <= x_val;
          dv_rem   <= '0;
          dv_div   <= y_val;
          dv_mod   <= (ins.kind == OP_MOD);
          dv_cnt   <= '1;
          state    <= e_div ? S_DIV : S_COMMIT;
        end
        S_DIV: begin
          dv_quo <= dv_quo_next;
          dv_rem <= dv_rem_next;
          dv_cnt <= dv_cnt - 4'd1;
          if (dv_cnt == '0) begin
            push_val <= dv_mod ? dv_rem_next : dv_quo_next;
            state    <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (out_free) begin
            unique case (pop_n)
              2'd1:    head <= head_p1;
              2'd2:    head <= head_p2;
              default: head <= head;
            endcase
            if (push_ok) begin
              tail <= tail_p1;
            end
            count <= count_after + CW'(push_ok);
            if (wr_en) begin
              rf_vld[wr_idx] <= 1'b1;
            end
            out_q       <= commit_res;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // value queue: write at commit, read both front entries on transfer
  always_ff @(posedge clk) begin
    if (commit && push_ok) begin
      q_mem[tail] <= push_val;
    end
    if (accept) begin
      q_rd0 <= q_mem[head];
      q_rd1 <= q_mem[head_p1];
    end
  end

  // register file: entries not yet written read as zero
  always_ff @(posedge clk) begin
    if (commit && wr_en) begin
      rf_mem[wr_idx] <= wr_val;
    end
    if (accept) begin
      rf_rd_a <= rf_mem[cmd.payload.reg_a];
      rf_rd_b <= rf_mem[cmd.payload.reg_b];
      rf_ok_a <= (cmd.payload.reg_a < RIDX_W'(NUM_REGS)) && rf_vld[cmd.payload.reg_a];
      rf_ok_b <= (cmd.payload.reg_b < RIDX_W'(NUM_REGS)) && rf_vld[cmd.payload.reg_b];
    end
  end

endmodule

FILE: sim/queue_machine_executor_top_test.sv
// Self-checking testbench for the queue machine execute unit: directed table, then random.
`timescale 1ns / 100ps

module queue_machine_executor_top_test;
  import qme_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 1024;
  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam logic [KIND_W-1:0] OP_UNDEFINED = 5'd31;
  localparam qme_res_t NO_EFFECT = '0;

  typedef struct {
    qme_cmd_t cmd;
    bit       known;
    qme_res_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;

  qme_stream_if #(.payload_t(qme_cmd_t)) cmd_ch ();
  qme_stream_if #(.payload_t(qme_res_t)) res_ch ();

  queue_machine_executor_top #(.QUEUE_DEPTH(QUEUE_DEPTH)) DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow state of the execute unit
  logic [DATA_W-1:0] queue_model[$];
  logic [DATA_W-1:0] reg_model[NUM_REGS];

  qme_res_t      pending_results[$];
  directed_row_t directed_rows[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned mismatch_count;
  int unsigned underflows_seen;
  int unsigned overflows_seen;
  int unsigned branches_seen;
  int unsigned prints_seen;
  int unsigned halts_seen;

  function automatic logic [DATA_W-1:0] model_pop(inout logic [1:0] err);
    if (queue_model.size() == 0) begin
      err = QERR_POP;
      return '0;
    end
    return queue_model.pop_front();
  endfunction

  function automatic void model_push(logic [DATA_W-1:0] value, inout logic [1:0] err);
    if (queue_model.size() >= QUEUE_DEPTH) begin
      if (err == QERR_NONE) err = QERR_PUSH;
    end else begin
      queue_model.insert(queue_model.size(), value);
    end
  endfunction

  function automatic logic [DATA_W-1:0] model_reg(logic [RIDX_W-1:0] idx);
    return (idx < NUM_REGS) ? reg_model[idx] : '0;
  endfunction

  function automatic qme_res_t execute_instruction(qme_cmd_t c);
    qme_res_t          r;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [1:0]        err;
    logic              jump;
    r    = '0;
    err  = QERR_NONE;
    jump = 1'b0;
    case (c.kind)
      OP_PUSH: model_push(c.immediate, err);
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
        x = model_pop(err);
        y = model_pop(err);
        case (c.kind)
          OP_ADD:  x = x + y;
          OP_SUB:  x = x - y;
          OP_MUL:  x = x * y;
          OP_DIV:  x = (y != 0) ? x / y : '0;
          default: x = (y != 0) ? x % y : '0;
        endcase
        model_push(x, err);
      end
      OP_POP_REG: begin
        x = model_pop(err);
        if (c.reg_a < NUM_REGS) reg_model[c.reg_a] = x;
      end
      OP_PUSH_REG: model_push(model_reg(c.reg_a), err);
      OP_PRN_NUM_Q: begin
        r.print_valid = 1'b1;
        r.print_value = model_pop(err);
      end
      OP_PRN_NUM_R: begin
        r.print_valid = 1'b1;
        r.print_value = model_reg(c.reg_a);
      end
      OP_PRN_CHR_Q: begin
        x = model_pop(err);
        r.print_valid = 1'b1;
        r.print_char  = 1'b1;
        r.print_value = {8'h00, x[7:0]};
      end
      OP_PRN_CHR_R: begin
        x = model_reg(c.reg_a);
        r.print_valid = 1'b1;
        r.print_char  = 1'b1;
        r.print_value = {8'h00, x[7:0]};
      end
      OP_JMP:      jump = 1'b1;
      OP_JMP_ZERO: jump = (model_reg(c.reg_a) == 0);
      OP_JMP_EQ:   jump = (model_reg(c.reg_a) == model_reg(c.reg_b));
      OP_JMP_GT:   jump = (model_reg(c.reg_a) > model_reg(c.reg_b));
      OP_QUIT:     r.halt = 1'b1;
      default: ;
    endcase
    if (jump) begin
      r.branch_taken  = 1'b1;
      r.branch_target = c.target;
    end
    r.queue_error = err;
    return r;
  endfunction

  function automatic void add_row(logic [KIND_W-1:0] kind, int unsigned ra, int unsigned rb,
                                  int unsigned imm, int unsigned tgt, bit known,
                                  qme_res_t want);
    directed_row_t row;
    row.cmd.kind      = kind;
    row.cmd.reg_a     = RIDX_W'(ra);
    row.cmd.reg_b     = RIDX_W'(rb);
    row.cmd.immediate = DATA_W'(imm);
    row.cmd.target    = ADDR_W'(tgt);
    row.known         = known;
    row.want          = want;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic logic [DATA_W-1:0] random_value();
    case ($urandom_range(7))
      0, 1:    return DATA_W'($urandom_range(3));
      2:       return 16'hFFFF;
      3:       return 16'h8000 | DATA_W'($urandom_range(255));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic qme_cmd_t random_instruction();
    qme_cmd_t    c;
    int unsigned roll;
    c.reg_a     = ($urandom_range(7) == 0) ? RIDX_W'($urandom_range(31))
                                           : RIDX_W'($urandom_range(NUM_REGS - 1));
    c.reg_b     = ($urandom_range(7) == 0) ? RIDX_W'($urandom_range(31))
                                           : RIDX_W'($urandom_range(NUM_REGS - 1));
    // equal operands make the compare jumps interesting
    if ($urandom_range(3) == 0) c.reg_b = c.reg_a;
    c.immediate = random_value();
    c.target    = ADDR_W'($urandom_range(1023));
    roll = $urandom_range(99);
    // mostly refill an empty queue rather than underflow it
    if (queue_model.size() == 0 && roll < 75) roll = 0;
    if (roll < 22)      c.kind = OP_PUSH;
    else if (roll < 30) c.kind = OP_PUSH_REG;
    else if (roll < 50) c.kind = KIND_W'($urandom_range(OP_ADD, OP_MOD));
    else if (roll < 58) c.kind = OP_POP_REG;
    else if (roll < 70) c.kind = KIND_W'($urandom_range(OP_PRN_NUM_Q, OP_PRN_CHR_R));
    else if (roll < 88) c.kind = KIND_W'($urandom_range(OP_JMP, OP_JMP_GT));
    else if (roll < 92) c.kind = OP_QUIT;
    else if (roll < 96) c.kind = KIND_W'($urandom_range(OP_QUIT + 1, OP_UNDEFINED));
    else                c.kind = KIND_W'($urandom_range(31));
    return c;
  endfunction

  task automatic send_instruction(qme_cmd_t c, bit known, qme_res_t want);
    qme_res_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.payload <= c;
    do @(posedge clk); while (!cmd_ch.ready);
    predicted = execute_instruction(c);
    pending_results.insert(pending_results.size(), known ? want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(negedge clk) res_ch.ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin : check_results
    qme_res_t want;
    qme_res_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = res_ch.payload;
      if (pending_results.size() == 0) begin
        $error("result transfer with no instruction outstanding");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        check_field("print_valid", 32'(want.print_valid), 32'(got.print_valid));
        check_field("print_value", 32'(want.print_value), 32'(got.print_value));
        check_field("print_char", 32'(want.print_char), 32'(got.print_char));
        check_field("branch_taken", 32'(want.branch_taken), 32'(got.branch_taken));
        check_field("branch_target", 32'(want.branch_target), 32'(got.branch_target));
        check_field("halt", 32'(want.halt), 32'(got.halt));
        check_field("queue_error", 32'(want.queue_error), 32'(got.queue_error));
        if (want.queue_error == QERR_POP) underflows_seen++;
        if (want.queue_error == QERR_PUSH) overflows_seen++;
        if (want.branch_taken) branches_seen++;
        if (want.print_valid) prints_seen++;
        if (want.halt) halts_seen++;
      end
    end
  end

  initial begin : stimulus
    qme_cmd_t    c;
    int unsigned roll;
    rst            = 1'b1;
    cmd_ch.valid   = 1'b0;
    cmd_ch.payload = '0;
    send_idle_pct  = 32;
    recv_stall_pct = 47;
    foreach (reg_model[i]) reg_model[i] = '0;

    // Read straight off the reset state and the opcode list
    add_row(OP_PRN_NUM_Q, 0, 0, 0, 0, 1, '{1'b1, 16'h0, 1'b0, 1'b0, 10'd0, 1'b0, QERR_POP});
    add_row(OP_PRN_CHR_R, 25, 0, 0, 0, 1, '{1'b1, 16'h0, 1'b1, 1'b0, 10'd0, 1'b0, QERR_NONE});
    add_row(OP_JMP, 0, 0, 0, 1023, 1, '{1'b0, 16'h0, 1'b0, 1'b1, 10'd1023, 1'b0, QERR_NONE});
    add_row(OP_JMP_ZERO, 31, 0, 0, 0, 1, '{1'b0, 16'h0, 1'b0, 1'b1, 10'd0, 1'b0, QERR_NONE});
    add_row(OP_JMP_EQ, 3, 31, 0, 512, 1, '{1'b0, 16'h0, 1'b0, 1'b1, 10'd512, 1'b0, QERR_NONE});
    add_row(OP_JMP_GT, 0, 1, 0, 1023, 1, NO_EFFECT);
    add_row(OP_QUIT, 31, 31, 16'hFFFF, 1023, 1,
            '{1'b0, 16'h0, 1'b0, 1'b0, 10'd0, 1'b1, QERR_NONE});
    add_row(OP_UNDEFINED, 31, 31, 16'hFFFF, 1023, 1, NO_EFFECT);
    add_row(OP_ADD, 0, 0, 0, 0, 1, '{1'b0, 16'h0, 1'b0, 1'b0, 10'd0, 1'b0, QERR_POP});
    add_row(OP_POP_REG, 7, 0, 0, 0, 1, NO_EFFECT);
    add_row(OP_PUSH, 0, 0, 16'hFFFF, 0, 1, NO_EFFECT);
    add_row(OP_PUSH, 0, 0, 16'hFFFF, 0, 1, NO_EFFECT);
    add_row(OP_MUL, 0, 0, 0, 0, 0, NO_EFFECT);
    add_row(OP_PUSH, 0, 0, 0, 0, 1, NO_EFFECT);
    add_row(OP_DIV, 0, 0, 0, 0, 0, NO_EFFECT);
    add_row(OP_PUSH, 0, 0, 16'hFFFF, 0, 1, NO_EFFECT);
    add_row(OP_SUB, 0, 0, 0, 0, 0, NO_EFFECT);
    add_row(OP_PUSH, 0, 0, 5, 0, 1, NO_EFFECT);
    add_row(OP_MOD, 0, 0, 0, 0, 0, NO_EFFECT);
    add_row(OP_POP_REG, 25, 0, 0, 0, 0, NO_EFFECT);
    add_row(OP_PUSH_REG, 25, 0, 0, 0, 0, NO_EFFECT);
    add_row(OP_POP_REG, 30, 0, 0, 0, 0, NO_EFFECT);
    add_row(OP_PUSH, 0, 0, 16'h12AB, 0, 1, NO_EFFECT);
    add_row(OP_PRN_CHR_Q, 0, 0, 0, 0, 0, NO_EFFECT);
    add_row(OP_JMP_GT, 25, 0, 0, 1, 0, NO_EFFECT);
    add_row(OP_PUSH_REG, 31, 0, 0, 0, 0, NO_EFFECT);
    add_row(OP_PRN_NUM_Q, 0, 0, 0, 0, 0, NO_EFFECT);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_instruction(directed_rows[i].cmd, directed_rows[i].known, directed_rows[i].want);

    repeat (100) send_instruction(random_instruction(), 1'b0, NO_EFFECT);

    // Fill the queue to the brim, then poke at it while full
    while (queue_model.size() < QUEUE_DEPTH) begin
      c = random_instruction();
      c.kind = ($urandom_range(3) == 0) ? OP_PUSH_REG : OP_PUSH;
      send_instruction(c, 1'b0, NO_EFFECT);
    end
    repeat (16) begin
      c = random_instruction();
      roll = $urandom_range(5);
      c.kind = (roll < 2) ? OP_PUSH : (roll < 4) ? OP_PUSH_REG
                                                 : KIND_W'($urandom_range(OP_ADD, OP_MOD));
      send_instruction(c, 1'b0, NO_EFFECT);
    end

    send_idle_pct  = 47;
    recv_stall_pct = 32;
    // Drain half with arithmetic, two reads each, so that the read side wraps as well
    while (queue_model.size() > QUEUE_DEPTH / 2) begin
      c = random_instruction();
      c.kind = KIND_W'($urandom_range(OP_ADD, OP_MOD));
      send_instruction(c, 1'b0, NO_EFFECT);
    end
    repeat (50) send_instruction(random_instruction(), 1'b0, NO_EFFECT);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (100) send_instruction(random_instruction(), 1'b0, NO_EFFECT);

    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d instructions sent, %0d results checked, %0d mismatches",
             items_sent, results_checked, mismatch_count);
    $display("covered %0d underflows, %0d overflows, %0d branches, %0d prints, %0d halts",
             underflows_seen, overflows_seen, branches_seen, prints_seen, halts_seen);
    if (mismatch_count == 0) begin
      $display("[queue_machine_executor_top] OK");
    end else begin
      $display("[queue_machine_executor_top] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("[queue_machine_executor_top] ERROR");
    $finish;
  end

endmodule
